@@ src/tgr_pkg.sv @@
// ---------------------------------------------------------------------------
// tgr_pkg: shared types and constants for the glyph rasterizer
// Geometry limits, control codes, fade math constants and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
package tgr_pkg;

    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_WIDTH  = 8;
    localparam int MAX_COLS     = 120;
    localparam int MAX_ROWS     = 40;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int GROW_W  = 4;
    localparam int CODE_W  = 8;
    localparam int FADDR_W = 12;
    localparam int COLOR_W = 24;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = 15;
    localparam int FONT_DEPTH = 4096;

    localparam logic [COLOR_W-1:0] FORE_RESET = 24'hffffff;
    localparam logic [COLOR_W-1:0] BACK_RESET = 24'h242418;

    // x/100 for x < 25600 as (x * 5243) >> 19
    localparam logic [12:0] FADE_RECIP = 13'd5243;
    localparam int          FADE_SHIFT = 19;

    localparam logic [CODE_W-1:0] CODE_BS = 8'd8;
    localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR = 8'd13;

    localparam logic [1:0] REG_FORE = 2'd0;
    localparam logic [1:0] REG_BACK = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;
    localparam logic [1:0] REG_ROWS = 2'd3;

    localparam logic [GROW_W-1:0] LAST_GROW = 4'(GLYPH_HEIGHT - 1);

    typedef struct packed {
        logic              accept;      // input word taken this cycle
        logic              font_wr;     // write font byte
        logic              cursor_upd;  // render word: capture cell, move cursor
        logic              s1_load;     // load fetch stage
        logic              s1_glyph;    // fetch stage entry carries a glyph row
        logic              from_input;  // address font by input code
        logic [GROW_W-1:0] row;
        logic              row_last;
    } tgr_cmd_t;

    typedef struct packed {
        logic s1_free;
        logic is_ctrl_code;
    } tgr_status_t;

    // 100 - (row*100/16)/2
    function automatic logic [PCT_W-1:0] fade_pct(input logic [GROW_W-1:0] row);
        logic [PCT_W-1:0] p;
        case (row)
            4'd0:    p = 7'd100;
            4'd1:    p = 7'd97;
            4'd2:    p = 7'd94;
            4'd3:    p = 7'd91;
            4'd4:    p = 7'd88;
            4'd5:    p = 7'd85;
            4'd6:    p = 7'd82;
            4'd7:    p = 7'd79;
            4'd8:    p = 7'd75;
            4'd9:    p = 7'd72;
            4'd10:   p = 7'd69;
            4'd11:   p = 7'd66;
            4'd12:   p = 7'd63;
            4'd13:   p = 7'd60;
            4'd14:   p = 7'd57;
            4'd15:   p = 7'd54;
            default: p = 7'd100;
        endcase
        return p;
    endfunction

endpackage

@@ src/tgr_ram.sv @@
// ---------------------------------------------------------------------------
// tgr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held
// while the read enable is low.
// ---------------------------------------------------------------------------
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/tgr_ctrl.sv @@
// ---------------------------------------------------------------------------
// tgr_ctrl: sequencing controller
// Takes input words and steps through the 16 glyph rows of a character.
// ---------------------------------------------------------------------------
module tgr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  tgr_pkg::tgr_status_t status,
    output tgr_pkg::tgr_cmd_t    cmd_o
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ROWS = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [tgr_pkg::GROW_W-1:0] row_cnt_reg, row_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        in_ready     = 1'b0;
        cmd_o        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = status.s1_free;
                cmd_o.accept = in_valid && status.s1_free;
                if (cmd_o.accept && in_cmd)
                begin
                    cmd_o.font_wr = 1'b1;
                end
                else if (cmd_o.accept)
                begin
                    cmd_o.cursor_upd = 1'b1;
                    cmd_o.s1_load    = 1'b1;
                    if (status.is_ctrl_code)
                    begin
                        cmd_o.row_last = 1'b1;
                    end
                    else
                    begin
                        // row 0 is fetched straight off the input code
                        cmd_o.s1_glyph   = 1'b1;
                        cmd_o.from_input = 1'b1;
                        row_cnt_next     = 4'd1;
                        state_next       = ST_ROWS;
                    end
                end
            end
            ST_ROWS:
            begin
                if (status.s1_free)
                begin
                    cmd_o.s1_load  = 1'b1;
                    cmd_o.s1_glyph = 1'b1;
                    cmd_o.row      = row_cnt_reg;
                    cmd_o.row_last = (row_cnt_reg == tgr_pkg::LAST_GROW);
                    row_cnt_next   = row_cnt_reg + 4'd1;
                    if (row_cnt_reg == tgr_pkg::LAST_GROW)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    // row 0 is always issued from idle, never from the row loop
    a_rows_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROWS |-> row_cnt_reg != '0)
        else $error("row loop entered with row counter at zero");

    // after the last row the controller is back in idle
    a_last_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROWS && cmd_o.s1_load && cmd_o.row_last |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after last row");
`endif

endmodule

@@ src/tgr_dp.sv @@
// ---------------------------------------------------------------------------
// tgr_dp: rasterizer datapath
// Config and cursor registers, font store, fetch stage and result register.
// ---------------------------------------------------------------------------
module tgr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tgr_pkg::tgr_cmd_t                 cmd_i,
    output tgr_pkg::tgr_status_t              status,
    input  logic [tgr_pkg::CODE_W-1:0]        char_code,
    input  logic [tgr_pkg::FADDR_W-1:0]       font_addr,
    input  logic [7:0]                        font_byte,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [tgr_pkg::COLOR_W-1:0]       cfg_wdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tgr_pkg::COL_W-1:0]         cell_col,
    output logic [tgr_pkg::ROW_W-1:0]         cell_row,
    output logic [tgr_pkg::GROW_W-1:0]        glyph_row,
    output logic                              glyph_valid,
    output logic [7:0]                        ink_mask,
    output logic [6:0]                        shadow_mask,
    output logic [tgr_pkg::COLOR_W-1:0]       ink_color,
    output logic [tgr_pkg::COLOR_W-1:0]       back_color,
    output logic                              scroll,
    output logic                              last
);

    function automatic logic [tgr_pkg::COL_W-1:0] eff_cols(input logic [tgr_pkg::COL_W-1:0] c);
        logic [tgr_pkg::COL_W-1:0] e;
        if (c == '0)
            e = 7'd1;
        else if (c > 7'(tgr_pkg::MAX_COLS))
            e = 7'(tgr_pkg::MAX_COLS);
        else
            e = c;
        return e;
    endfunction

    function automatic logic [tgr_pkg::ROW_W-1:0] eff_rows(input logic [tgr_pkg::ROW_W-1:0] r);
        logic [tgr_pkg::ROW_W-1:0] e;
        if (r == '0)
            e = 6'd1;
        else if (r > 6'(tgr_pkg::MAX_ROWS))
            e = 6'(tgr_pkg::MAX_ROWS);
        else
            e = r;
        return e;
    endfunction

    // config
    logic [tgr_pkg::COLOR_W-1:0] fore_reg, back_reg;
    logic [tgr_pkg::COL_W-1:0]   cols_reg;
    logic [tgr_pkg::ROW_W-1:0]   rows_reg;

    // cursor and per-item state
    logic [tgr_pkg::COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [tgr_pkg::ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [tgr_pkg::COL_W-1:0]   col0_reg;
    logic [tgr_pkg::ROW_W-1:0]   row0_reg;
    logic [tgr_pkg::CODE_W-1:0]  code_reg;
    logic                        scroll_reg, scroll_next;

    // fetch stage
    logic                        s1_valid_reg;
    logic                        s1_glyph_reg;
    logic                        s1_last_reg;
    logic [tgr_pkg::GROW_W-1:0]  s1_row_reg;
    logic [tgr_pkg::PROD_W-1:0]  s1_prod_reg [3];

    // result register
    logic                        out_valid_reg;
    logic [tgr_pkg::COL_W-1:0]   out_col_reg;
    logic [tgr_pkg::ROW_W-1:0]   out_row_reg;
    logic [tgr_pkg::GROW_W-1:0]  out_grow_reg;
    logic                        out_glyph_reg;
    logic [7:0]                  out_ink_reg;
    logic [6:0]                  out_shadow_reg;
    logic [tgr_pkg::COLOR_W-1:0] out_inkc_reg, out_backc_reg;
    logic                        out_scroll_reg, out_last_reg;
    logic [7:0]                  prev_ink_reg;

    logic                        out_adv;
    logic [7:0]                  font_rdata;
    logic [tgr_pkg::FADDR_W-1:0] rd_addr;
    logic [tgr_pkg::PCT_W-1:0]   pct;
    logic [tgr_pkg::COLOR_W-1:0] inkc;
    logic [6:0]                  shadow;
    logic [tgr_pkg::COL_W-1:0]   ec, new_ec;
    logic [tgr_pkg::ROW_W-1:0]   er, new_er;
    logic [tgr_pkg::COL_W:0]     col_w;
    logic [tgr_pkg::ROW_W:0]     row_w;

    assign out_adv = s1_valid_reg && (!out_valid_reg || out_ready);

    assign status.s1_free      = !s1_valid_reg || out_adv;
    assign status.is_ctrl_code = (char_code == tgr_pkg::CODE_CR) ||
                                 (char_code == tgr_pkg::CODE_BS) ||
                                 (char_code == tgr_pkg::CODE_LF);

    assign rd_addr = cmd_i.from_input ? {char_code, 4'd0} : {code_reg, cmd_i.row};

    tgr_ram #(
        .WIDTH (8),
        .DEPTH (tgr_pkg::FONT_DEPTH)
    ) u_font (
        .clk     (clk),
        .wr_en   (cmd_i.font_wr),
        .wr_addr (font_addr),
        .wr_data (font_byte),
        .rd_en   (cmd_i.s1_load && cmd_i.s1_glyph),
        .rd_addr (rd_addr),
        .rd_data (font_rdata)
    );

    // cursor move for a render word, or pull-in on a shrinking screen
    always_comb
    begin
        ec     = eff_cols(cols_reg);
        er     = eff_rows(rows_reg);
        new_ec = eff_cols(cfg_wdata[tgr_pkg::COL_W-1:0]);
        new_er = eff_rows(cfg_wdata[tgr_pkg::ROW_W-1:0]);
        col_w  = {1'b0, cur_col_reg};
        row_w  = {1'b0, cur_row_reg};
        scroll_next = 1'b0;
        case (char_code)
            tgr_pkg::CODE_CR:
            begin
                col_w = '0;
            end
            tgr_pkg::CODE_BS:
            begin
                if (col_w != '0)
                    col_w = col_w - 8'd1;
            end
            tgr_pkg::CODE_LF:
            begin
                col_w = '0;
                row_w = row_w + 7'd1;
            end
            default:
            begin
                col_w = col_w + 8'd1;
            end
        endcase
        if (col_w >= {1'b0, ec})
        begin
            col_w = '0;
            row_w = row_w + 7'd1;
        end
        if (row_w >= {1'b0, er})
        begin
            row_w       = {1'b0, er - 6'd1};
            scroll_next = 1'b1;
        end

        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cfg_we && cfg_index == tgr_pkg::REG_COLS)
        begin
            if (cur_col_reg >= new_ec)
                cur_col_next = new_ec - 7'd1;
        end
        else if (cfg_we && cfg_index == tgr_pkg::REG_ROWS)
        begin
            if (cur_row_reg >= new_er)
                cur_row_next = new_er - 6'd1;
        end
        else if (cmd_i.cursor_upd)
        begin
            cur_col_next = col_w[tgr_pkg::COL_W-1:0];
            cur_row_next = row_w[tgr_pkg::ROW_W-1:0];
        end
    end

    // second half of the fade: divide each channel product by 100
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [27:0] q;
            q = 28'(s1_prod_reg[i]) * 28'(tgr_pkg::FADE_RECIP);
            inkc[i*8 +: 8] = q[tgr_pkg::FADE_SHIFT +: 8];
        end
    end

    assign shadow = (s1_row_reg == '0) ? 7'd0 : (prev_ink_reg[7:1] & ~font_rdata[6:0]);
    assign pct    = tgr_pkg::fade_pct(cmd_i.row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg      <= tgr_pkg::FORE_RESET;
            back_reg      <= tgr_pkg::BACK_RESET;
            cols_reg      <= 7'(tgr_pkg::MAX_COLS);
            rows_reg      <= 6'(tgr_pkg::MAX_ROWS);
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tgr_pkg::REG_FORE: fore_reg <= cfg_wdata;
                    tgr_pkg::REG_BACK: back_reg <= cfg_wdata;
                    tgr_pkg::REG_COLS: cols_reg <= cfg_wdata[tgr_pkg::COL_W-1:0];
                    tgr_pkg::REG_ROWS: rows_reg <= cfg_wdata[tgr_pkg::ROW_W-1:0];
                    default:           fore_reg <= fore_reg;
                endcase
            end
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cmd_i.s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_adv)
                s1_valid_reg <= 1'b0;
            if (out_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_i.cursor_upd)
        begin
            col0_reg   <= cur_col_reg;
            row0_reg   <= cur_row_reg;
            code_reg   <= char_code;
            scroll_reg <= scroll_next;
        end
        if (cmd_i.s1_load)
        begin
            s1_glyph_reg <= cmd_i.s1_glyph;
            s1_last_reg  <= cmd_i.row_last;
            s1_row_reg   <= cmd_i.row;
            for (int i = 0; i < 3; i++)
                s1_prod_reg[i] <= 15'(fore_reg[i*8 +: 8]) * 15'(pct);
        end
        if (out_adv)
        begin
            out_col_reg    <= col0_reg;
            out_row_reg    <= row0_reg;
            out_glyph_reg  <= s1_glyph_reg;
            out_scroll_reg <= s1_last_reg && scroll_reg;
            out_last_reg   <= s1_last_reg;
            if (s1_glyph_reg)
            begin
                out_grow_reg   <= s1_row_reg;
                out_ink_reg    <= font_rdata;
                out_shadow_reg <= shadow;
                out_inkc_reg   <= inkc;
                out_backc_reg  <= (back_reg == fore_reg) ? inkc : back_reg;
                prev_ink_reg   <= font_rdata;
            end
            else
            begin
                out_grow_reg   <= '0;
                out_ink_reg    <= '0;
                out_shadow_reg <= '0;
                out_inkc_reg   <= '0;
                out_backc_reg  <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_col    = out_col_reg;
    assign cell_row    = out_row_reg;
    assign glyph_row   = out_grow_reg;
    assign glyph_valid = out_glyph_reg;
    assign ink_mask    = out_ink_reg;
    assign shadow_mask = out_shadow_reg;
    assign ink_color   = out_inkc_reg;
    assign back_color  = out_backc_reg;
    assign scroll      = out_scroll_reg;
    assign last        = out_last_reg;

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg < 7'(tgr_pkg::MAX_COLS) && cur_row_reg < 6'(tgr_pkg::MAX_ROWS))
        else $error("cursor outside screen");

    a_glyph_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_glyph_reg && out_last_reg |-> out_grow_reg == tgr_pkg::LAST_GROW)
        else $error("glyph ended before its last row");

    a_ctrl_word_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_glyph_reg |-> out_last_reg && out_ink_reg == '0)
        else $error("control code word malformed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.s1_load |-> !s1_valid_reg || out_adv)
        else $error("fetch stage overwritten");
`endif

endmodule

@@ src/tty_glyph_rasterizer.sv @@
// A render word's font store read and fetch stage load happen at the accepting
// edge; the result register takes its first result once free, as for a control code.
// A printable character issues one font row per cycle while the result side does
// not stall, and holds off new input words until its last row is issued; control
// codes and font writes are each taken as a single word.
// Reset: rst_n is asynchronous, active low; cursor to (0,0), registers to defaults.
// ---------------------------------------------------------------------------
// tty_glyph_rasterizer: text-mode character generator
// Renders character codes into 16 glyph-row words with ink mask, drop
// shadow, row-faded ink color and background; handles CR, BS and LF and
// takes font store writes on the same input channel.
// The font store is not cleared: entries are undefined until written.
// ---------------------------------------------------------------------------
module tty_glyph_rasterizer (
    input  logic                        clk,
    input  logic                        rst_n,
    // input words
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [tgr_pkg::CODE_W-1:0]  char_code,
    input  logic [tgr_pkg::FADDR_W-1:0] font_addr,
    input  logic [7:0]                  font_byte,
    // configuration writes
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [tgr_pkg::COLOR_W-1:0] cfg_wdata,
    // result words
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tgr_pkg::COL_W-1:0]   cell_col,
    output logic [tgr_pkg::ROW_W-1:0]   cell_row,
    output logic [tgr_pkg::GROW_W-1:0]  glyph_row,
    output logic                        glyph_valid,
    output logic [7:0]                  ink_mask,
    output logic [6:0]                  shadow_mask,
    output logic [tgr_pkg::COLOR_W-1:0] ink_color,
    output logic [tgr_pkg::COLOR_W-1:0] back_color,
    output logic                        scroll,
    output logic                        last
);

    // Controller owns the row counter and handshake on the input side.
    // Datapath owns config, cursor, the 4096x8 font RAM, a fetch stage
    // (row metadata plus channel*percent products, RAM read in flight) and
    // the result register. The fetch stage refills in the same cycle the
    // result register takes its word, so rows stream at one per cycle while
    // out_ready stays high and hold in place when it drops.
    tgr_pkg::tgr_cmd_t    cmd_w;
    tgr_pkg::tgr_status_t status_w;

    tgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_ready (in_ready),
        .status   (status_w),
        .cmd_o    (cmd_w)
    );

    tgr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_i       (cmd_w),
        .status      (status_w),
        .char_code   (char_code),
        .font_addr   (font_addr),
        .font_byte   (font_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .glyph_row   (glyph_row),
        .glyph_valid (glyph_valid),
        .ink_mask    (ink_mask),
        .shadow_mask (shadow_mask),
        .ink_color   (ink_color),
        .back_color  (back_color),
        .scroll      (scroll),
        .last        (last)
    );

endmodule

@@ tb/sv/tgr_tb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgr_tb_pkg: glyph row predictor and result checker
// Holds a cycle-free model of the rasterizer (registers, cursor, font
// bytes) and a queue of the glyph-row words each render is due to emit.
// ---------------------------------------------------------------------------
package tgr_tb_pkg;

    import tgr_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [GROW_W-1:0]  grow;
        logic               gvalid;
        logic [7:0]         ink;
        logic [6:0]         shadow;
        logic [COLOR_W-1:0] inkc;
        logic [COLOR_W-1:0] backc;
        logic               scroll;
        logic               last;
    } glyph_word_t;

    class raster_checker;

        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic [COL_W-1:0]   cols;
        logic [ROW_W-1:0]   rows;
        int unsigned        cur_col;
        int unsigned        cur_row;
        logic [7:0]         font [FONT_DEPTH];
        glyph_word_t        rows_due [$];

        int mismatches;
        int checked;
        int glyphs;
        int controls;
        int font_writes;
        int scrolls;

        function new();
            fore        = FORE_RESET;
            back        = BACK_RESET;
            cols        = COL_W'(MAX_COLS);
            rows        = ROW_W'(MAX_ROWS);
            cur_col     = 0;
            cur_row     = 0;
            mismatches  = 0;
            checked     = 0;
            glyphs      = 0;
            controls    = 0;
            font_writes = 0;
            scrolls     = 0;
        endfunction

        // zero counts as one, anything past the maximum as the maximum
        function int unsigned cols_eff();
            if (cols == 0) return 1;
            if (cols > MAX_COLS) return MAX_COLS;
            return 32'(cols);
        endfunction

        function int unsigned rows_eff();
            if (rows == 0) return 1;
            if (rows > MAX_ROWS) return MAX_ROWS;
            return 32'(rows);
        endfunction

        function void set_reg(logic [1:0] idx, logic [COLOR_W-1:0] val);
            case (idx)
                REG_FORE: fore = val;
                REG_BACK: back = val;
                REG_COLS: cols = val[COL_W-1:0];
                REG_ROWS: rows = val[ROW_W-1:0];
                default: ;
            endcase
            // shrinking the screen drags the cursor inside
            if (cur_col >= cols_eff()) cur_col = cols_eff() - 1;
            if (cur_row >= rows_eff()) cur_row = rows_eff() - 1;
        endfunction

        // channel * (100 - (row*100/16)/2) / 100
        function logic [COLOR_W-1:0] faded_ink(int r);
            int pct;
            int red;
            int grn;
            int blu;
            pct = 100 - (r * 100 / GLYPH_HEIGHT) / 2;
            red = int'(fore[23:16]) * pct / 100;
            grn = int'(fore[15:8]) * pct / 100;
            blu = int'(fore[7:0]) * pct / 100;
            return {red[7:0], grn[7:0], blu[7:0]};
        endfunction

        function void take_word(logic c, logic [CODE_W-1:0] code,
                                logic [FADDR_W-1:0] addr, logic [7:0] fbyte);
            glyph_word_t w;
            logic [COL_W-1:0] col0;
            logic [ROW_W-1:0] row0;
            logic [7:0] ink;
            logic [7:0] prev;
            logic printable;
            logic scr;
            if (c)
            begin
                font[addr] = fbyte;
                font_writes++;
                return;
            end
            col0 = COL_W'(cur_col);
            row0 = ROW_W'(cur_row);
            printable = 1'b0;
            scr = 1'b0;
            case (code)
                CODE_CR: cur_col = 0;
                CODE_BS: if (cur_col != 0) cur_col--;
                CODE_LF:
                begin
                    cur_col = 0;
                    cur_row++;
                end
                default:
                begin
                    printable = 1'b1;
                    cur_col++;
                end
            endcase
            if (cur_col >= cols_eff())
            begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= rows_eff())
            begin
                cur_row = rows_eff() - 1;
                scr = 1'b1;
                scrolls++;
            end
            if (printable)
            begin
                glyphs++;
                prev = 8'h00;
                for (int r = 0; r < GLYPH_HEIGHT; r++)
                begin
                    ink      = font[{code, 4'(r)}];
                    w.col    = col0;
                    w.row    = row0;
                    w.grow   = 4'(r);
                    w.gvalid = 1'b1;
                    w.ink    = ink;
                    w.shadow = (r == 0) ? 7'd0 : (prev[7:1] & ~ink[6:0]);
                    w.inkc   = faded_ink(r);
                    w.backc  = (back == fore) ? w.inkc : back;
                    w.last   = (r == GLYPH_HEIGHT - 1);
                    w.scroll = w.last & scr;
                    rows_due.push_back(w);
                    prev = ink;
                end
            end
            else
            begin
                controls++;
                w        = '0;
                w.col    = col0;
                w.row    = row0;
                w.scroll = scr;
                w.last   = 1'b1;
                rows_due.push_back(w);
            end
        endfunction

        function string show(glyph_word_t w);
            return $sformatf({"col=%0d row=%0d grow=%0d gv=%0b ink=%02h sh=%02h ",
                              "inkc=%06h backc=%06h scroll=%0b last=%0b"},
                             w.col, w.row, w.grow, w.gvalid, w.ink, w.shadow,
                             w.inkc, w.backc, w.scroll, w.last);
        endfunction

        function void check_row(glyph_word_t got);
            glyph_word_t want;
            if (rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %s", show(got));
                return;
            end
            want = rows_due.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result word mismatch");
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

    endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: glyph rasterizer check
// Loads glyphs into the font store, renders them and the CR/BS/LF codes
// over several screen and color settings, and compares every glyph-row
// word against a predictor, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;

    import tgr_pkg::*;
    import tgr_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 58;
    localparam int TAIL_CYCLES = 8;   // margin for words still in the result path

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 cmd = 1'b0;
    logic [CODE_W-1:0]    char_code = '0;
    logic [FADDR_W-1:0]   font_addr = '0;
    logic [7:0]           font_byte = '0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = REG_FORE;
    logic [COLOR_W-1:0]   cfg_wdata = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [COL_W-1:0]     cell_col;
    logic [ROW_W-1:0]     cell_row;
    logic [GROW_W-1:0]    glyph_row;
    logic                 glyph_valid;
    logic [7:0]           ink_mask;
    logic [6:0]           shadow_mask;
    logic [COLOR_W-1:0]   ink_color;
    logic [COLOR_W-1:0]   back_color;
    logic                 scroll;
    logic                 last;

    raster_checker sb;

    // percent chance per cycle that the sender / receiver sits idle
    int send_idle = 13;
    int recv_idle = 75;

    int words_sent = 0;
    int settings_done = 0;
    int cycles = 0;

    // font rows written so far per code; a code is only rendered once all
    // sixteen of its rows hold a written byte
    logic [15:0] rows_seen [256];
    logic        code_ready [256];
    int          ready_codes [$];
    logic        zero_loaded = 1'b0;

    always #5 clk = ~clk;

    tty_glyph_rasterizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .char_code   (char_code),
        .font_addr   (font_addr),
        .font_byte   (font_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .glyph_row   (glyph_row),
        .glyph_valid (glyph_valid),
        .ink_mask    (ink_mask),
        .shadow_mask (shadow_mask),
        .ink_color   (ink_color),
        .back_color  (back_color),
        .scroll      (scroll),
        .last        (last)
    );

    // ------------------------------------------------------------------
    // Result side: values seen right after the edge are the ones the
    // edge sampled, so a word counts when out_valid and out_ready were
    // both high going into it. out_ready is redrawn every cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_side
        glyph_word_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.col    = cell_col;
            got.row    = cell_row;
            got.grow   = glyph_row;
            got.gvalid = glyph_valid;
            got.ink    = ink_mask;
            got.shadow = shadow_mask;
            got.inkc   = ink_color;
            got.backc  = back_color;
            got.scroll = scroll;
            got.last   = last;
            sb.check_row(got);
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tty_glyph_rasterizer test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side. Entered right after an edge; idles at random, then holds
    // valid and payload until the edge that takes the word. Valid is left
    // high on return so back-to-back words need no second assignment.
    // ------------------------------------------------------------------
    task automatic send_word(logic c, logic [CODE_W-1:0] code,
                             logic [FADDR_W-1:0] addr, logic [7:0] fbyte);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        char_code <= code;
        font_addr <= addr;
        font_byte <= fbyte;
        do @(posedge clk); while (!in_ready);
        sb.take_word(c, code, addr, fbyte);
        words_sent++;
    endtask

    // char_code is a don't-care on a font write, so it gets random bits
    task automatic write_font(logic [FADDR_W-1:0] addr, logic [7:0] fbyte);
        int code;
        send_word(1'b1, CODE_W'($urandom_range(0, 255)), addr, fbyte);
        code = int'(addr[FADDR_W-1:4]);
        rows_seen[code][addr[3:0]] = 1'b1;
        if (&rows_seen[code] && !code_ready[code])
        begin
            code_ready[code] = 1'b1;
            ready_codes.push_back(code);
        end
    endtask

    // all sixteen rows of one glyph, with solid and empty rows mixed in
    task automatic load_glyph(logic [CODE_W-1:0] code);
        logic [7:0] fbyte;
        int pick;
        for (int r = 0; r < GLYPH_HEIGHT; r++)
        begin
            pick = $urandom_range(0, 7);
            fbyte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
            write_font({code, 4'(r)}, fbyte);
        end
    endtask

    // font fields are don't-care on a render word
    task automatic render(logic [CODE_W-1:0] code);
        send_word(1'b0, code, FADDR_W'($urandom), 8'($urandom));
    endtask

    // drop valid and wait until every expected word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // font writes leave nothing to wait for, so let the pipe idle after the drain
    task automatic quiesce();
        drain();
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(logic [COLOR_W-1:0] f, logic [COLOR_W-1:0] b,
                                 logic [COLOR_W-1:0] c, logic [COLOR_W-1:0] r);
        logic [1:0]         idx [4] = '{REG_FORE, REG_BACK, REG_COLS, REG_ROWS};
        logic [COLOR_W-1:0] val [4];
        val = '{f, b, c, r};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // one step of the random mix: mostly renders of loaded glyphs, some
    // cursor codes, glyph loads and stray font writes
    task automatic random_action();
        int sel;
        logic [CODE_W-1:0] code;
        sel = $urandom_range(0, 99);
        if (ready_codes.size() < 3 || sel < 6)
        begin
            code = zero_loaded ? CODE_W'($urandom_range(0, 255)) : '0;
            zero_loaded = 1'b1;
            load_glyph(code);
        end
        else if (sel < 14)
        begin
            write_font(FADDR_W'($urandom), 8'($urandom));
        end
        else if (sel < 30)
        begin
            case ($urandom_range(0, 2))
                0: render(CODE_CR);
                1: render(CODE_BS);
                default: render(CODE_LF);
            endcase
        end
        else
        begin
            render(CODE_W'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]));
        end
    endtask

    initial
    begin
        logic [7:0] pattern [16];
        logic [COLOR_W-1:0] f;
        logic [COLOR_W-1:0] b;
        int start;
        logic paused;

        pattern = '{8'hff, 8'h00, 8'h80, 8'h01, 8'haa, 8'h55,
                    8'hf0, 8'h0f, 8'hff, 8'hff, 8'h00, 8'h3c,
                    8'hc3, 8'h18, 8'he7, 8'h7f};
        sb = new();
        for (int i = 0; i < 256; i++)
        begin
            rows_seen[i]  = '0;
            code_ready[i] = 1'b0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --------------------------------------------------------------
        // Directed part, on the reset settings. The top glyph uses the
        // last font address; the pattern gives solid, empty and
        // alternating rows so shadows appear and get cut by ink.
        // --------------------------------------------------------------
        for (int r = 0; r < GLYPH_HEIGHT; r++)
            write_font({8'hff, 4'(r)}, pattern[r]);
        render(8'hff);          // cell (0,0)
        render(CODE_BS);        // back to column 0
        render(CODE_BS);        // backspace at column 0 stays put
        render(8'hff);
        render(CODE_CR);
        render(CODE_LF);
        render(8'hff);          // second text row
        write_font('0, 8'hff);  // first font address, fully set
        write_font(12'h800, 8'h00);

        // --------------------------------------------------------------
        // Random phases, each with its own screen and colors. Idling:
        // sender light / receiver heavy, then swapped, then none.
        // --------------------------------------------------------------
        for (int phase = 0; phase < 6; phase++)
        begin
            quiesce();
            case (phase / 2)
                0:
                begin
                    send_idle = 13;
                    recv_idle = 75;
                end
                1:
                begin
                    send_idle = 75;
                    recv_idle = 13;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            f = COLOR_W'($urandom);
            b = COLOR_W'($urandom);
            case (phase)
                // background equal to foreground, small screen
                0: apply_setting(f, f, COLOR_W'(5), COLOR_W'(3));
                // black on black, zero sizes act as one column / one row
                1: apply_setting('0, '0, '0, '0);
                // white on white, sizes past the maximum get clamped
                2: apply_setting('1, '1, COLOR_W'(7'h7f), COLOR_W'(6'h3f));
                3: apply_setting(f, '0, COLOR_W'(MAX_COLS), COLOR_W'(MAX_ROWS));
                // one cell: every glyph wraps and scrolls, cursor pulled in
                4: apply_setting(f, b, COLOR_W'(1), COLOR_W'(1));
                default: apply_setting(f, b, COLOR_W'($urandom_range(2, 16)),
                                       COLOR_W'($urandom_range(2, 8)));
            endcase

            start = words_sent;
            paused = 1'b0;
            while (words_sent - start < PHASE_WORDS)
            begin
                // hold off mid-phase until the block has emptied out
                if (phase == 1 && !paused && words_sent - start >= PHASE_WORDS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                random_action();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Rendered %0d glyphs and %0d cursor codes, %0d font writes, %0d scrolls",
                 sb.glyphs, sb.controls, sb.font_writes, sb.scrolls);
        $display("Checked %0d result words across %0d register settings, %0d mismatches",
                 sb.checked, settings_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tty_glyph_rasterizer test passed");
        else
            $display("tty_glyph_rasterizer test failed");
        $finish;
    end

endmodule
